FILE: hw/rtl/clru_pkg.sv
// ----------------------------------------------------------------------------
// clru_pkg: shared types for the Catmull-Rom line upsampler
// Command flags and index codes used by the front part, the command queue and
// the back part.
// ----------------------------------------------------------------------------
package clru_pkg;

  // Number of entries in the command queue between front and back.
  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned CmdPtrWidth   = $clog2(CmdQueueDepth);
  localparam int unsigned CmdCntWidth   = $clog2(CmdQueueDepth + 1);

  // Points of a command: a, b, c, d.
  localparam int unsigned CmdPoints = 4;
  // Coordinates of a point: x, y, z.
  localparam int unsigned Axes      = 3;

  localparam int unsigned PtA = 0;
  localparam int unsigned PtB = 1;
  localparam int unsigned PtC = 2;
  localparam int unsigned PtD = 3;

  localparam int unsigned AxisX = 0;
  localparam int unsigned AxisY = 1;
  localparam int unsigned AxisZ = 2;

  // Position of a line in progress.
  typedef enum logic [2:0] {
    SEEN_NONE = 3'b001,
    SEEN_ONE  = 3'b010,
    SEEN_MANY = 3'b100
  } seen_e;

  // Commands that one input point can produce, in emission order.
  typedef enum logic [3:0] {
    STEP_MID_INNER = 4'b0001,
    STEP_COPY_PREV = 4'b0010,
    STEP_MID_TAIL  = 4'b0100,
    STEP_COPY_LAST = 4'b1000
  } step_e;

  typedef struct packed {
    logic is_mid;
    logic strip_end;
  } cmd_flags_t;

endpackage

FILE: hw/rtl/catmull_rom_line_upsampler.sv
// ----------------------------------------------------------------------------
// catmull_rom_line_upsampler: 2x Catmull-Rom upsampler for one grid line
// Each accepted point is registered in the front part; its commands pass
// through the command queue and the output register. Throughput: one result
// beat per cycle while the output is not stalled, set by the single midpoint
// unit in the back part; a point emits 0 to 4 results, one at a time. Reset
// clears the line position and all queues; no clearing pass.
// ----------------------------------------------------------------------------
module catmull_rom_line_upsampler #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] pos_x_i,
  input  logic [COORD_WIDTH-1:0] pos_y_i,
  input  logic [COORD_WIDTH-1:0] pos_z_i,
  input  logic                   line_end_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] out_x_o,
  output logic [COORD_WIDTH-1:0] out_y_o,
  output logic [COORD_WIDTH-1:0] out_z_o,
  output logic                   is_midpoint_o,
  output logic                   strip_end_o
);

  typedef logic [clru_pkg::CmdPoints-1:0][clru_pkg::Axes-1:0][COORD_WIDTH-1:0] cmd_pts_t;

  logic                 fq_valid, fq_ready;
  cmd_pts_t             fq_pts;
  clru_pkg::cmd_flags_t fq_flags;
  logic                 qb_valid, qb_ready;
  cmd_pts_t             qb_pts;
  clru_pkg::cmd_flags_t qb_flags;

  clru_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .line_end_i  (line_end_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_pts_o   (fq_pts),
    .cmd_flags_o (fq_flags)
  );

  clru_queue #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_pts_i   (fq_pts),
    .wr_flags_i (fq_flags),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_pts_o   (qb_pts),
    .rd_flags_o (qb_flags)
  );

  clru_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (qb_valid),
    .cmd_ready_o   (qb_ready),
    .cmd_pts_i     (qb_pts),
    .cmd_flags_i   (qb_flags),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .is_midpoint_o (is_midpoint_o),
    .strip_end_o   (strip_end_o)
  );

endmodule

FILE: hw/rtl/clru_front.sv
// ----------------------------------------------------------------------------
// clru_front: point intake and command generation
// Holds the line history, classifies each accepted point and issues one
// command per cycle (midpoint or copy) into the command queue while it has room.
// ----------------------------------------------------------------------------
module clru_front #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [COORD_WIDTH-1:0]                    pos_x_i,
  input  logic [COORD_WIDTH-1:0]                    pos_y_i,
  input  logic [COORD_WIDTH-1:0]                    pos_z_i,
  input  logic                                      line_end_i,
  output logic                                      cmd_valid_o,
  input  logic                                      cmd_ready_i,
  output logic [clru_pkg::CmdPoints-1:0][clru_pkg::Axes-1:0][COORD_WIDTH-1:0] cmd_pts_o,
  output clru_pkg::cmd_flags_t                      cmd_flags_o
);

  typedef logic [clru_pkg::Axes-1:0][COORD_WIDTH-1:0] point_t;

  point_t              pt_in;
  point_t              item_q;
  logic                last_q;
  logic                busy_q, busy_d;
  logic                none_q;
  clru_pkg::step_e     step_q, stop_q;
  clru_pkg::seen_e     seen_q, seen_d;
  point_t              hist_q [3];
  point_t              hist_d [3];
  logic                accept;
  logic                retire;
  logic                push;
  clru_pkg::step_e     start_c, stop_c;
  logic                none_c;

  assign pt_in = {pos_z_i, pos_y_i, pos_x_i};

  assign cmd_valid_o = busy_q & ~none_q;
  assign push        = cmd_valid_o & cmd_ready_i;
  assign retire      = busy_q & (none_q | (push & (step_q == stop_q)));
  assign in_ready_o  = ~busy_q | retire;
  assign accept      = in_valid_i & in_ready_o;

  always_comb begin
    seen_d = seen_q;
    hist_d = hist_q;
    if (retire) begin
      if (last_q) begin
        seen_d = clru_pkg::SEEN_NONE;
      end else if (seen_q == clru_pkg::SEEN_NONE) begin
        seen_d    = clru_pkg::SEEN_ONE;
        hist_d[0] = item_q;
        hist_d[1] = item_q;
        hist_d[2] = item_q;
      end else begin
        seen_d    = clru_pkg::SEEN_MANY;
        hist_d[0] = hist_q[1];
        hist_d[1] = hist_q[2];
        hist_d[2] = item_q;
      end
    end
  end

  always_comb begin
    start_c = clru_pkg::STEP_COPY_LAST;
    stop_c  = clru_pkg::STEP_COPY_LAST;
    none_c  = 1'b0;
    case (seen_d)
      clru_pkg::SEEN_NONE: begin
        start_c = clru_pkg::STEP_COPY_LAST;
      end
      clru_pkg::SEEN_ONE: begin
        start_c = clru_pkg::STEP_MID_TAIL;
        none_c  = ~line_end_i;
      end
      clru_pkg::SEEN_MANY: begin
        start_c = clru_pkg::STEP_MID_INNER;
        stop_c  = line_end_i ? clru_pkg::STEP_COPY_LAST : clru_pkg::STEP_COPY_PREV;
      end
      default: begin
        start_c = clru_pkg::STEP_COPY_LAST;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (retire) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seen_q <= clru_pkg::SEEN_NONE;
      none_q <= 1'b0;
      step_q <= clru_pkg::STEP_COPY_LAST;
      stop_q <= clru_pkg::STEP_COPY_LAST;
    end else begin
      busy_q <= busy_d;
      seen_q <= seen_d;
      if (accept) begin
        none_q <= none_c;
        step_q <= start_c;
        stop_q <= stop_c;
      end else if (push) begin
        step_q <= clru_pkg::step_e'({step_q[2:0], 1'b0});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    if (accept) begin
      item_q <= pt_in;
      last_q <= line_end_i;
    end
  end

  always_comb begin
    cmd_pts_o   = '0;
    cmd_flags_o = '0;
    case (step_q)
      clru_pkg::STEP_MID_INNER: begin
        cmd_pts_o[clru_pkg::PtA] = hist_q[0];
        cmd_pts_o[clru_pkg::PtB] = hist_q[1];
        cmd_pts_o[clru_pkg::PtC] = hist_q[2];
        cmd_pts_o[clru_pkg::PtD] = item_q;
        cmd_flags_o.is_mid       = 1'b1;
      end
      clru_pkg::STEP_COPY_PREV: begin
        cmd_pts_o[clru_pkg::PtC] = hist_q[2];
      end
      clru_pkg::STEP_MID_TAIL: begin
        cmd_pts_o[clru_pkg::PtA] = hist_q[1];
        cmd_pts_o[clru_pkg::PtB] = hist_q[2];
        cmd_pts_o[clru_pkg::PtC] = item_q;
        cmd_pts_o[clru_pkg::PtD] = item_q;
        cmd_flags_o.is_mid       = 1'b1;
      end
      clru_pkg::STEP_COPY_LAST: begin
        cmd_pts_o[clru_pkg::PtC] = item_q;
        cmd_flags_o.strip_end    = last_q;
      end
      default: begin
        cmd_pts_o[clru_pkg::PtC] = item_q;
      end
    endcase
  end

endmodule

FILE: hw/rtl/clru_queue.sv
// ----------------------------------------------------------------------------
// clru_queue: command queue
// Short register queue that decouples command generation from evaluation.
// ----------------------------------------------------------------------------
module clru_queue #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      wr_valid_i,
  output logic                                      wr_ready_o,
  input  logic [clru_pkg::CmdPoints-1:0][clru_pkg::Axes-1:0][COORD_WIDTH-1:0] wr_pts_i,
  input  clru_pkg::cmd_flags_t                      wr_flags_i,
  output logic                                      rd_valid_o,
  input  logic                                      rd_ready_i,
  output logic [clru_pkg::CmdPoints-1:0][clru_pkg::Axes-1:0][COORD_WIDTH-1:0] rd_pts_o,
  output clru_pkg::cmd_flags_t                      rd_flags_o
);

  typedef logic [clru_pkg::CmdPoints-1:0][clru_pkg::Axes-1:0][COORD_WIDTH-1:0] cmd_pts_t;

  cmd_pts_t                          pts_q   [clru_pkg::CmdQueueDepth];
  clru_pkg::cmd_flags_t              flags_q [clru_pkg::CmdQueueDepth];
  logic [clru_pkg::CmdPtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [clru_pkg::CmdCntWidth-1:0]  count_q, count_d;
  logic                              do_wr, do_rd;

  assign wr_ready_o = (count_q != clru_pkg::CmdCntWidth'(clru_pkg::CmdQueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_valid_o & rd_ready_i;
  assign rd_pts_o   = pts_q[rd_ptr_q];
  assign rd_flags_o = flags_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      pts_q[wr_ptr_q]   <= wr_pts_i;
      flags_q[wr_ptr_q] <= wr_flags_i;
    end
  end

endmodule

FILE: hw/rtl/clru_back.sv
// ----------------------------------------------------------------------------
// clru_back: midpoint evaluation and output register
// Evaluates (-a + 9b + 9c - d + 8) >> 4 with saturation per axis, or passes a
// copied point, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module clru_back #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cmd_valid_i,
  output logic                                      cmd_ready_o,
  input  logic [clru_pkg::CmdPoints-1:0][clru_pkg::Axes-1:0][COORD_WIDTH-1:0] cmd_pts_i,
  input  clru_pkg::cmd_flags_t                      cmd_flags_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [COORD_WIDTH-1:0]                    out_x_o,
  output logic [COORD_WIDTH-1:0]                    out_y_o,
  output logic [COORD_WIDTH-1:0]                    out_z_o,
  output logic                                      is_midpoint_o,
  output logic                                      strip_end_o
);

  localparam int unsigned SumWidth = COORD_WIDTH + 5;

  typedef logic [clru_pkg::Axes-1:0][COORD_WIDTH-1:0] point_t;

  point_t               res_c;
  point_t               out_q;
  clru_pkg::cmd_flags_t flags_q;
  logic                 valid_q;
  logic                 take;

  for (genvar ax = 0; ax < clru_pkg::Axes; ax++) begin : g_axis
    logic signed [SumWidth-1:0]  a_e, b_e, c_e, d_e, bc, sum;
    logic        [COORD_WIDTH:0] quo;
    logic        [COORD_WIDTH-1:0] mid;

    always_comb begin
      a_e = {{5{cmd_pts_i[clru_pkg::PtA][ax][COORD_WIDTH-1]}}, cmd_pts_i[clru_pkg::PtA][ax]};
      b_e = {{5{cmd_pts_i[clru_pkg::PtB][ax][COORD_WIDTH-1]}}, cmd_pts_i[clru_pkg::PtB][ax]};
      c_e = {{5{cmd_pts_i[clru_pkg::PtC][ax][COORD_WIDTH-1]}}, cmd_pts_i[clru_pkg::PtC][ax]};
      d_e = {{5{cmd_pts_i[clru_pkg::PtD][ax][COORD_WIDTH-1]}}, cmd_pts_i[clru_pkg::PtD][ax]};
      bc  = b_e + c_e;
      sum = (bc <<< 3) + bc - a_e - d_e + SumWidth'(8);
      quo = sum[SumWidth-1:4];
      if (quo[COORD_WIDTH] != quo[COORD_WIDTH-1]) begin
        mid = quo[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                               : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
        mid = quo[COORD_WIDTH-1:0];
      end
      res_c[ax] = cmd_flags_i.is_mid ? mid : cmd_pts_i[clru_pkg::PtC][ax];
    end
  end

  assign cmd_ready_o = ~valid_q | out_ready_i;
  assign take        = cmd_valid_i & cmd_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q   <= res_c;
      flags_q <= cmd_flags_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_x_o       = out_q[clru_pkg::AxisX];
  assign out_y_o       = out_q[clru_pkg::AxisY];
  assign out_z_o       = out_q[clru_pkg::AxisZ];
  assign is_midpoint_o = flags_q.is_mid;
  assign strip_end_o   = flags_q.strip_end;

endmodule
